@@ rtl/core/e2q_pkg.sv @@
// Package: shared constants, types and CORDIC angle table for the Euler to quaternion unit.
package e2q_pkg;
   localparam int AngleWidth   = 16;
   localparam int QuatWidth    = 16;
   localparam int CordicStages = 16;
   localparam int CordicWidth  = 20;
   localparam int ZWidth       = 20;
   localparam logic signed [CordicWidth-1:0] CordicGain = 20'sd39797;
   localparam logic signed [AngleWidth:0] HalfPi = 17'sd25736;
   localparam logic signed [AngleWidth+1:0] PiQ14 = 18'sd51472;
   localparam logic signed [QuatWidth-1:0] QuatOne = 16'sd16384;

   // One angle's sine and cosine, Q.16
   typedef struct packed {
      logic signed [CordicWidth-1:0] cos_val;
      logic signed [CordicWidth-1:0] sin_val;
   } sincos_type;

   // Arctangent table, Q.16 radians
   function automatic logic signed [ZWidth-1:0] atan_entry(input int idx);
      logic signed [ZWidth-1:0] val;
      case (idx)
         0: val = 20'sd51472;
         1: val = 20'sd30386;
         2: val = 20'sd16055;
         3: val = 20'sd8150;
         4: val = 20'sd4091;
         5: val = 20'sd2047;
         6: val = 20'sd1024;
         7: val = 20'sd512;
         8: val = 20'sd256;
         9: val = 20'sd128;
         10: val = 20'sd64;
         11: val = 20'sd32;
         12: val = 20'sd16;
         13: val = 20'sd8;
         14: val = 20'sd4;
         15: val = 20'sd2;
         default: val = '0;
      endcase
      return val;
   endfunction
endpackage

@@ rtl/core/e2q_cordic_lane.sv @@
// Module: one pipelined rotation-mode CORDIC lane producing half-angle sine and cosine.
module e2q_cordic_lane (
   input  logic                                   clock,
   input  logic                                   advance,
   input  logic signed [e2q_pkg::AngleWidth-1:0]  angle,
   output e2q_pkg::sincos_type                    result
);
   import e2q_pkg::*;

   logic signed [CordicWidth-1:0] x_ff [CordicStages+1];
   logic signed [CordicWidth-1:0] y_ff [CordicStages+1];
   logic signed [ZWidth-1:0]      z_ff [CordicStages+1];
   logic                          flip_ff [CordicStages+1];
   logic signed [AngleWidth+1:0]  h_ext;
   logic signed [AngleWidth+1:0]  h_fold;
   logic                          flip_in;

   // Fold the half angle into plus or minus half pi
   always_comb begin
      h_ext   = {{2{angle[AngleWidth-1]}}, angle};
      h_fold  = h_ext;
      flip_in = 1'b0;
      if (h_ext > 18'(HalfPi)) begin
         h_fold  = PiQ14 - h_ext;
         flip_in = 1'b1;
      end else if (h_ext < -18'(HalfPi)) begin
         h_fold  = -PiQ14 - h_ext;
         flip_in = 1'b1;
      end
   end

   // Load the first stage
   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= CordicGain;
         y_ff[0]    <= '0;
         z_ff[0]    <= {h_fold, 2'b00};
         flip_ff[0] <= flip_in;
      end
   end

   // Advance the rotation stages
   for (genvar i = 0; i < CordicStages; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!z_ff[i][ZWidth-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_entry(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_entry(i);
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   assign result.cos_val = flip_ff[CordicStages] ? -x_ff[CordicStages] : x_ff[CordicStages];
   assign result.sin_val = y_ff[CordicStages];
endmodule

@@ rtl/core/e2q_merge.sv @@
// Module: pipelined triple products, sums, rounding and saturation into the quaternion.
module e2q_merge (
   input  logic                                  clock,
   input  logic                                  advance,
   input  e2q_pkg::sincos_type                   roll_sc,
   input  e2q_pkg::sincos_type                   pitch_sc,
   input  e2q_pkg::sincos_type                   yaw_sc,
   output logic signed [e2q_pkg::QuatWidth-1:0]  quat_w,
   output logic signed [e2q_pkg::QuatWidth-1:0]  quat_x,
   output logic signed [e2q_pkg::QuatWidth-1:0]  quat_y,
   output logic signed [e2q_pkg::QuatWidth-1:0]  quat_z
);
   import e2q_pkg::*;

   localparam int PairWidth = 2 * CordicWidth;
   localparam int TripWidth = 3 * CordicWidth;
   localparam int SumWidth  = TripWidth + 1;

   logic signed [PairWidth-1:0]      cc_ff, cs_ff, sc_ff, ss_ff;
   logic signed [CordicWidth-1:0]    cy_ff, sy_ff;
   logic signed [TripWidth-1:0]      p_ff [8];
   logic signed [SumWidth-1:0]       s_ff [4];
   logic signed [QuatWidth-1:0]      q_ff [4];
   logic signed [SumWidth-1:0]       sum_in [4];

   // Multiply roll by pitch
   always_ff @(posedge clock) begin
      if (advance) begin
         cc_ff <= roll_sc.cos_val * pitch_sc.cos_val;
         cs_ff <= roll_sc.cos_val * pitch_sc.sin_val;
         sc_ff <= roll_sc.sin_val * pitch_sc.cos_val;
         ss_ff <= roll_sc.sin_val * pitch_sc.sin_val;
         cy_ff <= yaw_sc.cos_val;
         sy_ff <= yaw_sc.sin_val;
      end
   end

   // Multiply by yaw
   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff[0] <= cc_ff * cy_ff;
         p_ff[1] <= ss_ff * sy_ff;
         p_ff[2] <= sc_ff * cy_ff;
         p_ff[3] <= cs_ff * sy_ff;
         p_ff[4] <= cs_ff * cy_ff;
         p_ff[5] <= sc_ff * sy_ff;
         p_ff[6] <= cc_ff * sy_ff;
         p_ff[7] <= ss_ff * cy_ff;
      end
   end

   // Combine pairs of products
   always_comb begin
      sum_in[0] = SumWidth'(p_ff[0]) + SumWidth'(p_ff[1]);
      sum_in[1] = SumWidth'(p_ff[2]) - SumWidth'(p_ff[3]);
      sum_in[2] = SumWidth'(p_ff[4]) + SumWidth'(p_ff[5]);
      sum_in[3] = SumWidth'(p_ff[6]) - SumWidth'(p_ff[7]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 4; k++) s_ff[k] <= sum_in[k];
      end
   end

   // Round half up and saturate
   for (genvar k = 0; k < 4; k++) begin : g_round
      logic signed [SumWidth-1:0] rnd;
      logic signed [SumWidth-35:0] shifted;
      always_comb begin
         rnd     = s_ff[k] + (SumWidth'(1) <<< 33);
         shifted = rnd[SumWidth-1:34];
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            if (shifted > (SumWidth-34)'(QuatOne)) q_ff[k] <= QuatOne;
            else if (shifted < -(SumWidth-34)'(QuatOne)) q_ff[k] <= -QuatOne;
            else q_ff[k] <= shifted[QuatWidth-1:0];
         end
      end
   end

   assign quat_w = q_ff[0];
   assign quat_x = q_ff[1];
   assign quat_y = q_ff[2];
   assign quat_z = q_ff[3];
endmodule

@@ rtl/core/euler_to_quaternion_unit.sv @@
// Top level: ZYX Euler angles to attitude quaternion, fully pipelined.
// Usage:
//   Input channel req_*: roll, pitch and yaw in signed Q3.13 radians. A word is
//   taken when req_valid is high and req_stall is low.
//   Result channel rsp_*: quaternion w, x, y, z in signed Q1.14, saturated to
//   plus or minus one. A word leaves when rsp_valid is high and rsp_stall low.
// Pipeline: 17 CORDIC stages in three parallel lanes, two multiply stages, one sum
//   stage and one rounding stage.
// Throughput: one word per cycle, fully pipelined, unless a held result stalls.
// Stall: the whole pipeline holds while a finished word waits and the receiver
//   stalls; req_stall then follows rsp_stall. An empty output slot never stalls.
// Reset: clears the valid bits of all stages; no other state is reset.
module euler_to_quaternion_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [e2q_pkg::AngleWidth-1:0] req_roll_angle,
   input  logic signed [e2q_pkg::AngleWidth-1:0] req_pitch_angle,
   input  logic signed [e2q_pkg::AngleWidth-1:0] req_yaw_angle,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [e2q_pkg::QuatWidth-1:0]  rsp_quat_w,
   output logic signed [e2q_pkg::QuatWidth-1:0]  rsp_quat_x,
   output logic signed [e2q_pkg::QuatWidth-1:0]  rsp_quat_y,
   output logic signed [e2q_pkg::QuatWidth-1:0]  rsp_quat_z
);
   import e2q_pkg::*;

   localparam int Depth = CordicStages + 5;

   logic [Depth-1:0]  valid_ff;
   logic [Depth-1:0]  valid_in;
   logic              advance;
   sincos_type        roll_sc, pitch_sc, yaw_sc;

   // Advance unless the output word is held
   assign advance   = !(valid_ff[Depth-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = valid_ff[Depth-1];

   always_comb begin
      valid_in = valid_ff;
      if (advance) valid_in = {valid_ff[Depth-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   e2q_cordic_lane u_roll  (.clock, .advance, .angle(req_roll_angle),  .result(roll_sc));
   e2q_cordic_lane u_pitch (.clock, .advance, .angle(req_pitch_angle), .result(pitch_sc));
   e2q_cordic_lane u_yaw   (.clock, .advance, .angle(req_yaw_angle),   .result(yaw_sc));

   e2q_merge u_merge (
      .clock,
      .advance,
      .roll_sc,
      .pitch_sc,
      .yaw_sc,
      .quat_w(rsp_quat_w),
      .quat_x(rsp_quat_x),
      .quat_y(rsp_quat_y),
      .quat_z(rsp_quat_z)
   );
endmodule

@@ verif/euler_to_quaternion_unit_checker.sv @@
// Checker: watches both channels, predicts each quaternion word and compares it.
module euler_to_quaternion_unit_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic signed [e2q_pkg::AngleWidth-1:0] req_roll_angle,
   input  logic signed [e2q_pkg::AngleWidth-1:0] req_pitch_angle,
   input  logic signed [e2q_pkg::AngleWidth-1:0] req_yaw_angle,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic signed [e2q_pkg::QuatWidth-1:0]  rsp_quat_w,
   input  logic signed [e2q_pkg::QuatWidth-1:0]  rsp_quat_x,
   input  logic signed [e2q_pkg::QuatWidth-1:0]  rsp_quat_y,
   input  logic signed [e2q_pkg::QuatWidth-1:0]  rsp_quat_z,
   output int                                    error_count,
   output int                                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import e2q_pkg::*;

   typedef struct packed {
      logic signed [QuatWidth-1:0] w;
      logic signed [QuatWidth-1:0] x;
      logic signed [QuatWidth-1:0] y;
      logic signed [QuatWidth-1:0] z;
   } quat_type;

   quat_type expected_quats[$];

   // Half angle (Q.14) to cosine and sine (Q.16) by rotation CORDIC
   function automatic void half_angle_sincos(input longint h, output longint c,
                                             output longint s);
      longint x, y, z, nx;
      bit     flip;
      flip = 0;
      if (h > HalfPi) begin
         h = PiQ14 - h;
         flip = 1;
      end else if (h < -HalfPi) begin
         h = -PiQ14 - h;
         flip = 1;
      end
      x = CordicGain;
      y = 0;
      z = h * 4;
      for (int i = 0; i < CordicStages; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - longint'(atan_entry(i));
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + longint'(atan_entry(i));
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = y;
   endfunction

   // Q.48 sum to saturated Q1.14, rounding half up
   function automatic logic signed [QuatWidth-1:0] round_saturate(input longint v);
      longint r;
      r = (v + (longint'(1) <<< 33)) >>> 34;
      if (r > QuatOne) r = QuatOne;
      if (r < -QuatOne) r = -QuatOne;
      return r[QuatWidth-1:0];
   endfunction

   function automatic quat_type predict_quat(input logic signed [AngleWidth-1:0] roll,
                                             input logic signed [AngleWidth-1:0] pitch,
                                             input logic signed [AngleWidth-1:0] yaw);
      longint   cr, sr, cp, sp, cy, sy;
      quat_type q;
      half_angle_sincos(longint'(roll), cr, sr);
      half_angle_sincos(longint'(pitch), cp, sp);
      half_angle_sincos(longint'(yaw), cy, sy);
      q.w = round_saturate(cr * cp * cy + sr * sp * sy);
      q.x = round_saturate(sr * cp * cy - cr * sp * sy);
      q.y = round_saturate(cr * sp * cy + sr * cp * sy);
      q.z = round_saturate(cr * cp * sy - sr * sp * cy);
      return q;
   endfunction

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   // Predict on each accepted angle word, compare on each accepted result word
   always @(posedge clock) begin
      quat_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_quats.push_back(predict_quat(req_roll_angle, req_pitch_angle,
                                                  req_yaw_angle));
         if (rsp_valid && !rsp_stall) begin
            if (expected_quats.size() == 0) begin
               $error("result word with no expectation waiting");
               error_count++;
            end else begin
               want = expected_quats.pop_front();
               if (rsp_quat_w !== want.w) begin
                  $error("quat_w expected %0d actual %0d", want.w, rsp_quat_w);
                  error_count++;
               end
               if (rsp_quat_x !== want.x) begin
                  $error("quat_x expected %0d actual %0d", want.x, rsp_quat_x);
                  error_count++;
               end
               if (rsp_quat_y !== want.y) begin
                  $error("quat_y expected %0d actual %0d", want.y, rsp_quat_y);
                  error_count++;
               end
               if (rsp_quat_z !== want.z) begin
                  $error("quat_z expected %0d actual %0d", want.z, rsp_quat_z);
                  error_count++;
               end
            end
         end
         pending_count = expected_quats.size();
      end
   end
endmodule

@@ verif/euler_to_quaternion_unit_test.sv @@
// Testbench top: drives angle words and result stalls, and reports the verdict.
module euler_to_quaternion_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import e2q_pkg::*;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   logic signed [AngleWidth-1:0] req_roll_angle, req_pitch_angle, req_yaw_angle;
   logic signed [QuatWidth-1:0]  rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;
   int error_count, pending_count;
   int send_idle_pct, stall_pct;
   bit hold_off;

   euler_to_quaternion_unit dut (.*);
   euler_to_quaternion_unit_checker checker_inst (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Timeout
   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   // Drive result stalls from the falling edge; hold off long on request
   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_stall <= 1;
            repeat (120) @(negedge clock);
            hold_off = 0;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Offer one angle word and hold it until taken; valid stays up for the next word
   task automatic send_angles(input logic [AngleWidth-1:0] roll,
                              input logic [AngleWidth-1:0] pitch,
                              input logic [AngleWidth-1:0] yaw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid       <= 1;
      req_roll_angle  <= roll;
      req_pitch_angle <= pitch;
      req_yaw_angle   <= yaw;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic logic [AngleWidth-1:0] random_angle();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return AngleWidth'($urandom());
      if (pick == 1) return AngleWidth'($urandom_range(51472) - 25736 + 0);
      return AngleWidth'(int'($urandom_range(2 * 25736)) - 25736);
   endfunction

   initial begin
      logic [AngleWidth-1:0] edges[10];
      edges = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd1, -16'sd1, 16'sd12868,
                -16'sd12868, 16'sd32767, -16'sd32768, 16'sd25737};
      req_valid = 0;
      req_roll_angle = 0;
      req_pitch_angle = 0;
      req_yaw_angle = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off = 0;
      reset = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: extremes, quarter turns, gimbal lock, folded half angles
      for (int i = 0; i < 10; i++)
         send_angles(edges[i], edges[(i + 3) % 10], edges[(i + 7) % 10]);
      send_angles(16'sd0, 16'sd12868, 16'sd0);
      send_angles(16'sd25736, 16'sd25736, 16'sd25736);
      send_angles(-16'sd25736, -16'sd25736, -16'sd25736);
      send_angles(16'hFFFF, 16'h7FFF, 16'h8000);
      send_angles(16'h5555, 16'hAAAA, 16'h0F0F);

      // Random phases with varied idling
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 88; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 88; end
            default: begin send_idle_pct = 13; stall_pct = 13; end
         endcase
         if (phase == 4) hold_off = 1;
         for (int n = 0; n < 200; n++)
            send_angles(random_angle(), random_angle(), random_angle());
         // Pause until the pipeline drains
         if (phase == 5) begin
            req_valid <= 0;
            while (pending_count != 0) @(negedge clock);
         end
      end

      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

@@ euler_to_quaternion_unit.f @@
rtl/core/e2q_pkg.sv
rtl/core/e2q_cordic_lane.sv
rtl/core/e2q_merge.sv
rtl/core/euler_to_quaternion_unit.sv
verif/euler_to_quaternion_unit_checker.sv
verif/euler_to_quaternion_unit_test.sv
